>>> hw/rtl/cvsc_pkg.sv
// Shared types and constants of the chunked value slice checker.
// Used by every module in hw/rtl; depends on nothing else.
package cvsc_pkg;

  // Fixed field widths.
  localparam int unsigned CfgW    = 30;
  localparam int unsigned NumW    = 31;
  localparam int unsigned StateW  = 20;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned OutLenW = 11;
  // Remainder by the chunk size (chunk size at most 8192).
  localparam int unsigned RemW    = 13;
  // (chunk count - 1) * chunk size, signed.
  localparam int unsigned Cm1CsW  = 35;
  localparam int unsigned DsizeW  = 17;

  // Header bytes of the two plain formats.
  localparam int unsigned HdrPlain = 4;
  localparam int unsigned HdrShort = 1;

  // Commands.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CHUNK  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Chunk header formats; every other code means compressed.
  typedef enum logic [1:0] {
    FMT_PLAIN = 2'd0,
    FMT_SHORT = 2'd1,
    FMT_COMP  = 2'd2,
    FMT_EXT   = 2'd3
  } fmt_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_COMPRESSED = 3'd1,
    ST_SEQUENCE   = 3'd2,
    ST_RANGE      = 3'd3,
    ST_SIZE       = 3'd4,
    ST_MISSING    = 3'd5,
    ST_ABORTED    = 3'd6,
    ST_UNUSED     = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TOTAL_SIZE   = 2'd0,
    REG_SLICE_OFFSET = 2'd1,
    REG_SLICE_LENGTH = 2'd2,
    REG_NONE         = 2'd3
  } reg_e;

  // Input request payload.
  typedef struct packed {
    logic [1:0]       command;
    logic [NumW-1:0]  chunk_number;
    logic [1:0]       chunk_format;
    logic [SizeW-1:0] stored_size;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [2:0]         status;
    logic [CfgW-1:0]    dest_offset;
    logic [OutLenW-1:0] src_offset;
    logic [OutLenW-1:0] copy_length;
    logic [StateW-1:0]  expected_number;
  } out_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    cmd_e                     cmd;
    logic [NumW-1:0]          num;
    logic                     compressed;
    logic signed [DsizeW-1:0] dsize;
  } work_t;

  // Slice geometry derived from the configuration registers.
  typedef struct packed {
    logic [StateW-1:0]        first_chunk;
    logic [StateW-1:0]        last_chunk;
    logic [StateW-1:0]        chunk_count;
    logic signed [Cm1CsW-1:0] cm1cs;
    logic [RemW-1:0]          first_src;
    logic [RemW-1:0]          last_end;
    logic [CfgW-1:0]          eff_total;
    logic [CfgW-1:0]          slice_offset;
  } info_t;

endpackage

>>> hw/rtl/chunked_value_slice_checker_top.sv
// Chunked value slice checker: one result per request via the queue, the execute stage
// and the output register; one request per cycle sustained while out_ready_i is high
// (two-entry queue plus two back stages). A 5-stage constant-divide pipeline derives the
// slice geometry from the registers; requests wait for it after reset and each cfg write.
// Reset (rst_ni low, asynchronous) restores the register defaults and the slice state.
// Depends on cvsc_pkg, cvsc_cdiv, cvsc_front and cvsc_back.
module chunked_value_slice_checker_top #(
  parameter int unsigned CHUNK_SIZE = 1996
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cvsc_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cvsc_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [cvsc_pkg::CfgW-1:0]  cfg_data_i
);

  localparam int unsigned CW     = cvsc_pkg::CfgW;
  localparam int unsigned SW     = cvsc_pkg::StateW;
  localparam logic [2:0]  Settle = 3'd5;

  logic [CW-1:0]      total_q, offset_q, length_q;
  logic [2:0]         settle_q;
  logic [CW-1:0]      eff_total, eff_len;
  logic [CW:0]        end_raw;
  logic [CW-1:0]      x_off_q, x_end_q, x_tm1_q;
  logic [CW-1:0]      q_off, q_end, q_tm1;
  logic [cvsc_pkg::RemW-1:0] r_off, r_end, r_tm1;
  logic [SW-1:0]      count;
  logic signed [SW:0] cm1;
  cvsc_pkg::info_t    info_q, info;
  logic               q_valid, q_pop;
  cvsc_pkg::work_t    q_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= CW'(1);
      offset_q <= '0;
      length_q <= CW'(1);
    end else if (cfg_we_i) begin
      unique case (cvsc_pkg::reg_e'(cfg_index_i))
        cvsc_pkg::REG_TOTAL_SIZE:   total_q  <= cfg_data_i;
        cvsc_pkg::REG_SLICE_OFFSET: offset_q <= cfg_data_i;
        cvsc_pkg::REG_SLICE_LENGTH: length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off requests until the derived geometry has caught up with the registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= Settle;
    end else if (cfg_we_i) begin
      settle_q <= Settle;
    end else if (settle_q != 3'd0) begin
      settle_q <= settle_q - 3'd1;
    end
  end

  // Zero size or length count as one byte; the slice end is clipped to the value.
  assign eff_total = (total_q == '0) ? CW'(1) : total_q;
  assign eff_len   = (length_q == '0) ? CW'(1) : length_q;
  assign end_raw   = {1'b0, offset_q} + {1'b0, eff_len} - (CW+1)'(1);

  always_ff @(posedge clk_i) begin
    x_off_q <= offset_q;
    x_tm1_q <= eff_total - CW'(1);
    x_end_q <= (end_raw < {1'b0, eff_total - CW'(1)}) ? end_raw[CW-1:0]
                                                       : eff_total - CW'(1);
  end

  // Chunk numbers of the slice start, the slice end and the last chunk.
  cvsc_cdiv #(.CHUNK_SIZE(CHUNK_SIZE)) u_div_off (
    .clk_i  (clk_i),
    .x_i    (x_off_q),
    .quot_o (q_off),
    .rem_o  (r_off)
  );

  cvsc_cdiv #(.CHUNK_SIZE(CHUNK_SIZE)) u_div_end (
    .clk_i  (clk_i),
    .x_i    (x_end_q),
    .quot_o (q_end),
    .rem_o  (r_end)
  );

  cvsc_cdiv #(.CHUNK_SIZE(CHUNK_SIZE)) u_div_tm1 (
    .clk_i  (clk_i),
    .x_i    (x_tm1_q),
    .quot_o (q_tm1),
    .rem_o  (r_tm1)
  );

  // Chunk count kept modulo the state width, and the bytes before the last chunk.
  assign count = q_tm1[SW-1:0] + SW'(1);
  assign cm1   = $signed({1'b0, count}) - (SW+1)'(1);

  always_ff @(posedge clk_i) begin
    info_q.first_chunk  <= q_off[SW-1:0];
    info_q.last_chunk   <= q_end[SW-1:0];
    info_q.chunk_count  <= count;
    info_q.cm1cs        <= cvsc_pkg::Cm1CsW'(cm1) * cvsc_pkg::Cm1CsW'(CHUNK_SIZE);
    info_q.first_src    <= r_off;
    info_q.last_end     <= r_end;
    info_q.eff_total    <= '0;
    info_q.slice_offset <= '0;
  end

  // The back end takes the total size and slice offset straight from the live registers.
  always_comb begin
    info              = info_q;
    info.eff_total    = eff_total;
    info.slice_offset = offset_q;
    // The remainder of the last-byte position is not needed past the divider.
    if (r_tm1 == '1) begin
      info.eff_total = eff_total;
    end
  end

  cvsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (settle_q != 3'd0),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  cvsc_back #(.CHUNK_SIZE(CHUNK_SIZE)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .info_i      (info),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/cvsc_cdiv.sv
// Three-stage divider of a 30-bit value by the constant chunk size.
// Uses a reciprocal multiply and one correction step; depends on cvsc_pkg.
module cvsc_cdiv #(
  parameter int unsigned CHUNK_SIZE = 1996
) (
  input  logic                          clk_i,
  input  logic [cvsc_pkg::CfgW-1:0]     x_i,
  output logic [cvsc_pkg::CfgW-1:0]     quot_o,
  output logic [cvsc_pkg::RemW-1:0]     rem_o
);

  localparam int unsigned Shift  = cvsc_pkg::CfgW;
  localparam logic [Shift:0] Recip = (Shift+1)'((64'd1 << Shift) / CHUNK_SIZE);
  localparam int unsigned ProdW  = 2 * Shift + 1;
  localparam int unsigned EstW   = cvsc_pkg::RemW + 1;

  logic [ProdW-1:0]              prod;
  logic [cvsc_pkg::CfgW-1:0]     x1_q, qe1_q;
  logic [cvsc_pkg::CfgW-1:0]     qcs;
  logic [cvsc_pkg::CfgW-1:0]     qe2_q;
  logic [EstW-1:0]               rem2_q;
  logic [cvsc_pkg::CfgW-1:0]     quot_q;
  logic [cvsc_pkg::RemW-1:0]     rem_q;

  // Stage one: quotient estimate, never above the true quotient by construction.
  assign prod = ProdW'(x_i) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    qe1_q <= prod[2*Shift-1:Shift];
  end

  // Stage two: remainder of the estimate, below twice the chunk size.
  assign qcs = cvsc_pkg::CfgW'(qe1_q * cvsc_pkg::CfgW'(CHUNK_SIZE));

  always_ff @(posedge clk_i) begin
    qe2_q  <= qe1_q;
    rem2_q <= EstW'(x1_q - qcs);
  end

  // Stage three: one compare and subtract corrects the estimate.
  always_ff @(posedge clk_i) begin
    if (rem2_q >= EstW'(CHUNK_SIZE)) begin
      quot_q <= qe2_q + cvsc_pkg::CfgW'(1);
      rem_q  <= cvsc_pkg::RemW'(rem2_q - EstW'(CHUNK_SIZE));
    end else begin
      quot_q <= qe2_q;
      rem_q  <= cvsc_pkg::RemW'(rem2_q);
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/cvsc_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Holds a two-entry queue; depends on cvsc_pkg.
module cvsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hold_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cvsc_pkg::in_t       in_data_i,
  output logic                q_valid_o,
  output cvsc_pkg::work_t     q_data_o,
  input  logic                q_pop_i
);

  cvsc_pkg::work_t   work;
  cvsc_pkg::work_t   mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push;
  logic              pop;
  logic signed [cvsc_pkg::DsizeW-1:0] stored;

  // Classify the request: header bytes and compressed flag.
  assign stored = $signed({1'b0, in_data_i.stored_size});

  always_comb begin
    work.cmd        = cvsc_pkg::cmd_e'(in_data_i.command);
    work.num        = in_data_i.chunk_number;
    work.compressed = 1'b0;
    unique case (cvsc_pkg::fmt_e'(in_data_i.chunk_format))
      cvsc_pkg::FMT_PLAIN: begin
        work.dsize = stored - cvsc_pkg::DsizeW'(cvsc_pkg::HdrPlain);
      end
      cvsc_pkg::FMT_SHORT: begin
        work.dsize = stored - cvsc_pkg::DsizeW'(cvsc_pkg::HdrShort);
      end
      default: begin
        work.dsize      = '0;
        work.compressed = 1'b1;
      end
    endcase
  end

  // Queue handshakes.
  assign in_ready_o = (cnt_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_data_o   = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= work;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/cvsc_back.sv
// Back end: checks each queued request against the slice state and builds its result.
// Execute stage plus output register; depends on cvsc_pkg.
module cvsc_back #(
  parameter int unsigned CHUNK_SIZE = 1996
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cvsc_pkg::work_t     q_data_i,
  output logic                q_pop_o,
  input  cvsc_pkg::info_t     info_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cvsc_pkg::out_t      out_data_o
);

  localparam int unsigned SW    = cvsc_pkg::StateW;
  localparam int unsigned CW    = cvsc_pkg::CfgW;
  localparam int unsigned RW    = cvsc_pkg::RemW;
  localparam int unsigned EndW  = cvsc_pkg::DsizeW + 1;
  localparam int unsigned WantW = cvsc_pkg::Cm1CsW + 2;
  localparam int unsigned MulW  = SW + 14;

  // Slice state.
  logic [SW-1:0]                        next_q, first_q, last_q, count_q;
  logic signed [cvsc_pkg::Cm1CsW-1:0]   cm1cs_q;
  logic                                 err_q;

  // Execute stage registers.
  logic                   e_valid_q;
  cvsc_pkg::status_e      e_status_q;
  logic                   e_ok_q;
  logic [RW-1:0]          e_src_q;
  logic [EndW-1:0]        e_len_q;
  logic [SW-1:0]          e_exp_q;
  logic [CW-1:0]          e_prod_q;

  // Output register.
  logic                   o_valid_q;
  cvsc_pkg::out_t         o_data_q;

  logic                   o_free, e_free, exec;
  cvsc_pkg::status_e      status;
  logic                   ok_chunk;
  logic [RW-1:0]          src;
  logic signed [EndW-1:0] end_pos, len;
  logic [SW-1:0]          exp_num;
  logic                   start, bump, set_err;
  logic signed [WantW-1:0] want;
  logic                   below_last;
  logic [MulW-1:0]        prod;
  logic [CW-1:0]          dest;

  // Pipeline flow control.
  assign o_free  = !o_valid_q || out_ready_i;
  assign e_free  = !e_valid_q || o_free;
  assign exec    = q_valid_i && e_free;
  assign q_pop_o = exec;

  // Expected data size of this chunk.
  assign below_last = ({1'b0, q_data_i.num} + 32'd1) < {12'b0, count_q};

  always_comb begin
    if (below_last) begin
      want = WantW'(CHUNK_SIZE);
    end else begin
      want = $signed({{(WantW-CW){1'b0}}, info_i.eff_total}) - WantW'(cm1cs_q);
    end
  end

  // Request checks in their fixed order.
  always_comb begin
    status   = cvsc_pkg::ST_OK;
    ok_chunk = 1'b0;
    exp_num  = next_q;
    start    = 1'b0;
    bump     = 1'b0;
    set_err  = 1'b0;
    unique case (q_data_i.cmd)
      cvsc_pkg::CMD_START: begin
        start   = 1'b1;
        exp_num = '0;
      end
      cvsc_pkg::CMD_NOP: begin
        exp_num = '0;
      end
      cvsc_pkg::CMD_FINISH: begin
        if (err_q) begin
          status = cvsc_pkg::ST_ABORTED;
        end else if (next_q <= last_q) begin
          status  = cvsc_pkg::ST_MISSING;
          set_err = 1'b1;
        end
      end
      cvsc_pkg::CMD_CHUNK: begin
        if (err_q) begin
          status = cvsc_pkg::ST_ABORTED;
        end else if (q_data_i.compressed) begin
          status  = cvsc_pkg::ST_COMPRESSED;
          set_err = 1'b1;
        end else if (q_data_i.num != {{(cvsc_pkg::NumW-SW){1'b0}}, next_q}) begin
          status  = cvsc_pkg::ST_SEQUENCE;
          set_err = 1'b1;
        end else if (next_q > last_q) begin
          status  = cvsc_pkg::ST_RANGE;
          set_err = 1'b1;
        end else if (WantW'(q_data_i.dsize) != want) begin
          status  = cvsc_pkg::ST_SIZE;
          set_err = 1'b1;
        end else begin
          ok_chunk = 1'b1;
          bump     = 1'b1;
        end
      end
      default: begin
        status = cvsc_pkg::ST_UNUSED;
      end
    endcase
  end

  // Copy window inside the chunk; the chunk number equals next_q when it is used.
  always_comb begin
    src     = (next_q == first_q) ? info_i.first_src : '0;
    end_pos = (next_q == last_q) ? $signed({{(EndW-RW){1'b0}}, info_i.last_end})
                                 : EndW'(q_data_i.dsize) - EndW'(1);
    if (end_pos >= $signed({{(EndW-RW){1'b0}}, src})) begin
      len = end_pos - $signed({{(EndW-RW){1'b0}}, src}) + EndW'(1);
    end else begin
      len = '0;
    end
  end

  // Chunk start position in the whole value.
  assign prod = MulW'(next_q) * MulW'(CHUNK_SIZE);

  // Slice state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
      count_q <= SW'(1);
      cm1cs_q <= '0;
      err_q   <= 1'b0;
    end else if (exec) begin
      if (start) begin
        next_q  <= info_i.first_chunk;
        first_q <= info_i.first_chunk;
        last_q  <= info_i.last_chunk;
        count_q <= info_i.chunk_count;
        cm1cs_q <= info_i.cm1cs;
        err_q   <= 1'b0;
      end else begin
        if (bump) begin
          next_q <= next_q + SW'(1);
        end
        if (set_err) begin
          err_q <= 1'b1;
        end
      end
    end
  end

  // Execute stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_free) begin
      e_valid_q <= exec;
    end
  end

  // Execute stage payload.
  always_ff @(posedge clk_i) begin
    if (exec) begin
      e_status_q <= status;
      e_ok_q     <= ok_chunk;
      e_src_q    <= src;
      e_len_q    <= len;
      e_exp_q    <= exp_num;
      e_prod_q   <= prod[CW-1:0];
    end
  end

  // Destination offset in the slice result.
  assign dest = e_prod_q - info_i.slice_offset + CW'(e_src_q);

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_free) begin
      o_valid_q <= e_valid_q;
    end
  end

  // Output register payload; offsets and length only for a good chunk.
  always_ff @(posedge clk_i) begin
    if (o_free && e_valid_q) begin
      o_data_q.status          <= e_status_q;
      o_data_q.expected_number <= e_exp_q;
      if (e_ok_q) begin
        o_data_q.dest_offset <= dest;
        o_data_q.src_offset  <= e_src_q[cvsc_pkg::OutLenW-1:0];
        o_data_q.copy_length <= e_len_q[cvsc_pkg::OutLenW-1:0];
      end else begin
        o_data_q.dest_offset <= '0;
        o_data_q.src_offset  <= '0;
        o_data_q.copy_length <= '0;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule
